[sv/depth_map_median_filter_top_defines.svh]
// Assertion macros for the checker file of the depth map median filter.
`ifndef DEPTH_MAP_MEDIAN_FILTER_TOP_DEFINES_SVH
`define DEPTH_MAP_MEDIAN_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DMMF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DMMF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/dmmf_pkg.sv]
// Types and constants shared by the depth map median filter modules.
package dmmf_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SEL,
    ST_OUT
  } top_state_e;

  typedef enum logic {
    SEL_IDLE,
    SEL_SCAN
  } sel_state_e;

  localparam int CFG_DW   = 12;
  localparam int CFG_IW   = 2;
  localparam int ROW_W    = 12;
  localparam int RADIUS_W = 2;

  localparam logic [CFG_IW-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_RADIUS = 2'd2;

  localparam logic [CFG_DW-1:0]   RST_WIDTH  = 12'd640;
  localparam logic [CFG_DW-1:0]   RST_HEIGHT = 12'd480;
  localparam logic [RADIUS_W-1:0] RST_RADIUS = 2'd1;

endpackage

[sv/dmmf_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module dmmf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/dmmf_select.sv]
// Window median unit: radix selection, one bit per pass over the window in the line store.
module dmmf_select #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_RADIUS = 3,
  parameter int DEPTH_BITS = 16,
  localparam int STORE_ROWS = 2 * MAX_RADIUS + 2,
  localparam int WIN_SIDE   = 2 * MAX_RADIUS + 1,
  localparam int WIN_MAX    = WIN_SIDE * WIN_SIDE,
  localparam int AW         = $clog2(STORE_ROWS * MAX_WIDTH),
  localparam int SW         = $clog2(STORE_ROWS),
  localparam int CW         = $clog2(MAX_WIDTH + 1),
  localparam int KW         = $clog2(WIN_MAX + 1),
  localparam int RADW       = $clog2(MAX_RADIUS + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [SW-1:0]         r0_slot_i,
  input  logic [RADW:0]         rows_m1_i,
  input  logic [CW-1:0]         c0_i,
  input  logic [CW-1:0]         c1_i,
  input  logic [KW-1:0]         k_i,
  output logic                  rd_en_o,
  output logic [AW-1:0]         rd_addr_o,
  input  logic [DEPTH_BITS-1:0] rd_data_i,
  output logic                  done_o,
  output logic [DEPTH_BITS-1:0] med_o
);
  import dmmf_pkg::*;

  sel_state_e state_q, state_d;

  logic [SW-1:0]         slot0_q, slot0_d, slot_q, slot_d;
  logic [RADW:0]         rows_q, rows_d, row_left_q, row_left_d;
  logic [CW-1:0]         c0_q, c0_d, c1_q, c1_d, col_q, col_d;
  logic                  issue_done_q, issue_done_d, rd_vld_q, rd_vld_d, done_q, done_d;
  logic [KW-1:0]         cnt_q, cnt_d, k_q, k_d;
  logic [DEPTH_BITS-1:0] prefix_q, prefix_d, bit_q, bit_d, himask_q, himask_d;
  logic                  match;

  assign match = (((rd_data_i ^ prefix_q) & himask_q) == '0) && ((rd_data_i & bit_q) == '0);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SEL_IDLE: begin
        if (start_i) state_d = SEL_SCAN;
      end
      SEL_SCAN: begin
        if (issue_done_q && !rd_vld_q && bit_q[0]) state_d = SEL_IDLE;
      end
      default: state_d = SEL_IDLE;
    endcase
  end

  // Datapath
  always_comb begin
    slot0_d      = slot0_q;
    rows_d       = rows_q;
    c0_d         = c0_q;
    c1_d         = c1_q;
    slot_d       = slot_q;
    row_left_d   = row_left_q;
    col_d        = col_q;
    issue_done_d = issue_done_q;
    rd_vld_d     = 1'b0;
    done_d       = 1'b0;
    cnt_d        = cnt_q;
    k_d          = k_q;
    prefix_d     = prefix_q;
    bit_d        = bit_q;
    himask_d     = himask_q;
    rd_en_o      = 1'b0;

    if (state_q == SEL_IDLE) begin
      if (start_i) begin
        slot0_d      = r0_slot_i;
        rows_d       = rows_m1_i;
        c0_d         = c0_i;
        c1_d         = c1_i;
        slot_d       = r0_slot_i;
        row_left_d   = rows_m1_i;
        col_d        = c0_i;
        issue_done_d = 1'b0;
        cnt_d        = '0;
        k_d          = k_i;
        prefix_d     = '0;
        bit_d        = {1'b1, {(DEPTH_BITS-1){1'b0}}};
        himask_d     = '0;
      end
    end else begin
      // issue one window read per cycle
      if (!issue_done_q) begin
        rd_en_o  = 1'b1;
        rd_vld_d = 1'b1;
        if (col_q == c1_q) begin
          col_d = c0_q;
          if (row_left_q == '0) begin
            issue_done_d = 1'b1;
          end else begin
            row_left_d = row_left_q - 1'b1;
            slot_d     = (slot_q == SW'(STORE_ROWS - 1)) ? '0 : slot_q + 1'b1;
          end
        end else begin
          col_d = col_q + 1'b1;
        end
      end
      if (rd_vld_q && match) cnt_d = cnt_q + 1'b1;
      // pass complete: settle this bit, rewind the scan
      if (issue_done_q && !rd_vld_q) begin
        if (k_q >= cnt_q) begin
          prefix_d = prefix_q | bit_q;
          k_d      = k_q - cnt_q;
        end
        cnt_d        = '0;
        issue_done_d = 1'b0;
        slot_d       = slot0_q;
        row_left_d   = rows_q;
        col_d        = c0_q;
        himask_d     = himask_q | bit_q;
        bit_d        = bit_q >> 1;
        if (bit_q[0]) done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SEL_IDLE;
      issue_done_q <= 1'b0;
      rd_vld_q     <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      issue_done_q <= issue_done_d;
      rd_vld_q     <= rd_vld_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q    <= slot0_d;
    rows_q     <= rows_d;
    c0_q       <= c0_d;
    c1_q       <= c1_d;
    slot_q     <= slot_d;
    row_left_q <= row_left_d;
    col_q      <= col_d;
    cnt_q      <= cnt_d;
    k_q        <= k_d;
    prefix_q   <= prefix_d;
    bit_q      <= bit_d;
    himask_q   <= himask_d;
  end

  assign rd_addr_o = AW'(32'(slot_q) * MAX_WIDTH) + AW'(col_q);
  assign done_o    = done_q;
  assign med_o     = prefix_q;

endmodule

[sv/depth_map_median_filter_top.sv]
// Depth map median filter: line store, position tracking and stream handshake.
//
// Input beats (s_axis) carry one raster-order pixel: tdata holds depth and valid
// mark, tuser marks a drain beat that only flushes results still pending at the
// end of a frame. Output beats (m_axis) carry the median of the clipped square
// window of side 2*radius+1 around each pixel, in raster order; tlast flags the
// last pixel of the frame. Configuration is a plain write port (index 0 width,
// 1 height, 2 radius); a write to one of these restarts the frame.
// One beat is handled at a time. A beat that yields no result goes from the check
// state back to idle. A beat that completes a window waits for the median unit,
// which does one pass per depth bit over the window (up to 49 pixels), one line
// store read per cycle through the single read port.
// The output register lets the next beat be taken while a result waits; a
// stalled receiver holds tdata/tlast and, once a second result is ready, blocks
// further input. Reset clears all positions and loads 640 x 480, radius 1; the
// line store is not cleared, as only entries written in the current frame are
// ever read.
module depth_map_median_filter_top #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_RADIUS = 3,
  parameter int DEPTH_BITS = 16,
  localparam int TDW       = ((DEPTH_BITS + 1 + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dmmf_pkg::CFG_IW-1:0]   cfg_idx_i,
  input  logic [dmmf_pkg::CFG_DW-1:0]   cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [TDW-1:0]                s_axis_tdata,   // depth_in, valid_in, zero pad
  input  logic                          s_axis_tuser,   // kind
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [TDW-1:0]                m_axis_tdata,   // depth_out, valid_out, zero pad
  output logic                          m_axis_tlast
);
  import dmmf_pkg::*;

  localparam int STORE_ROWS = 2 * MAX_RADIUS + 2;
  localparam int WIN_SIDE   = 2 * MAX_RADIUS + 1;
  localparam int WIN_MAX    = WIN_SIDE * WIN_SIDE;
  localparam int ENTRIES    = STORE_ROWS * MAX_WIDTH;
  localparam int AW         = $clog2(ENTRIES);
  localparam int SW         = $clog2(STORE_ROWS);
  localparam int CW         = $clog2(MAX_WIDTH + 1);
  localparam int RW         = ROW_W;
  localparam int KW         = $clog2(WIN_MAX + 1);
  localparam int RADW       = $clog2(MAX_RADIUS + 1);

  top_state_e state_q, state_d;

  logic [CFG_DW-1:0]   width_q, width_d, height_q, height_d;
  logic [RADIUS_W-1:0] radius_q, radius_d;
  logic [RW-1:0]       in_row_q, in_row_d, out_row_q, out_row_d;
  logic [CW-1:0]       in_col_q, in_col_d, out_col_q, out_col_d;
  logic [SW-1:0]       in_slot_q, in_slot_d, out_slot_q, out_slot_d;
  logic                last_q, last_d;
  logic                m_valid_q, m_valid_d, m_last_q, m_last_d, m_flag_q, m_flag_d;
  logic [DEPTH_BITS-1:0] m_depth_q, m_depth_d;

  // effective configuration
  logic [CW-1:0]   w;
  logic [RW-1:0]   h;
  logic [RADW-1:0] rad;

  always_comb begin
    if (width_q == '0) w = CW'(1);
    else if (32'(width_q) > MAX_WIDTH) w = CW'(MAX_WIDTH);
    else w = CW'(width_q);
    h   = (height_q == '0) ? RW'(1) : RW'(height_q);
    rad = (32'(radius_q) > MAX_RADIUS) ? RADW'(MAX_RADIUS) : RADW'(radius_q);
  end

  // window bounds of the next output pixel
  logic [RW:0]     need_r_w;
  logic [CW:0]     need_c_w;
  logic [RW-1:0]   need_r, r0, r_off;
  logic [CW-1:0]   need_c, c0;
  logic [RADW:0]   rows_m1, cols_m1;
  logic [KW-1:0]   win_n, win_k;
  logic [SW:0]     slot_wrap;
  logic [SW-1:0]   r0_slot;
  logic            win_ready, result_go;

  always_comb begin
    need_r_w  = {1'b0, out_row_q} + (RW+1)'(rad);
    need_c_w  = {1'b0, out_col_q} + (CW+1)'(rad);
    need_r    = (need_r_w < {1'b0, h}) ? RW'(need_r_w) : h - 1'b1;
    need_c    = (need_c_w < {1'b0, w}) ? CW'(need_c_w) : w - 1'b1;
    r0        = (out_row_q >= RW'(rad)) ? out_row_q - RW'(rad) : '0;
    c0        = (out_col_q >= CW'(rad)) ? out_col_q - CW'(rad) : '0;
    rows_m1   = (RADW+1)'(need_r - r0);
    cols_m1   = (RADW+1)'(need_c - c0);
    win_n     = KW'(32'(rows_m1 + 1'b1) * 32'(cols_m1 + 1'b1));
    win_k     = win_n >> 1;
    r_off     = out_row_q - r0;
    slot_wrap = {1'b0, out_slot_q} + (SW+1)'(STORE_ROWS) - (SW+1)'(r_off);
    r0_slot   = (out_slot_q >= SW'(r_off)) ? out_slot_q - SW'(r_off) : SW'(slot_wrap);
    win_ready = (in_row_q >= h) || (need_r < in_row_q)
             || ((need_r == in_row_q) && (need_c < in_col_q));
    result_go = (out_row_q < h) && win_ready;
  end

  // median unit and line store
  logic                  sel_start, sel_done, rd_en, mem_we;
  logic [AW-1:0]         rd_addr, wr_addr;
  logic [DEPTH_BITS-1:0] rd_data, wr_data, sel_med;

  dmmf_select #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_RADIUS(MAX_RADIUS),
    .DEPTH_BITS(DEPTH_BITS)
  ) u_select (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (sel_start),
    .r0_slot_i(r0_slot),
    .rows_m1_i(rows_m1),
    .c0_i     (c0),
    .c1_i     (need_c),
    .k_i      (win_k),
    .rd_en_o  (rd_en),
    .rd_addr_o(rd_addr),
    .rd_data_i(rd_data),
    .done_o   (sel_done),
    .med_o    (sel_med)
  );

  dmmf_ram #(
    .WIDTH(DEPTH_BITS),
    .DEPTH(ENTRIES)
  ) u_line_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  logic in_beat, out_free;
  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_beat) state_d = ST_CHECK;
      ST_CHECK: state_d = result_go ? ST_SEL : ST_IDLE;
      ST_SEL:   if (sel_done) state_d = ST_OUT;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs of the state machine
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    sel_start     = (state_q == ST_CHECK) && result_go;
  end

  // Position tracking, line store writes, output register
  logic            restart;
  logic [RW-1:0]   in_row_b;
  logic [CW-1:0]   in_col_b, wcol;
  logic [SW-1:0]   in_slot_b;

  always_comb begin
    width_d    = width_q;
    height_d   = height_q;
    radius_d   = radius_q;
    in_row_d   = in_row_q;
    in_col_d   = in_col_q;
    in_slot_d  = in_slot_q;
    out_row_d  = out_row_q;
    out_col_d  = out_col_q;
    out_slot_d = out_slot_q;
    last_d     = last_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_depth_d  = m_depth_q;
    m_flag_d   = m_flag_q;
    m_last_d   = m_last_q;
    mem_we     = 1'b0;
    wcol       = '0;
    wr_data    = '0;

    // a finished frame whose outputs are all out starts over
    restart   = (in_row_q >= h) && (out_row_q >= h);
    in_row_b  = restart ? '0 : in_row_q;
    in_col_b  = restart ? '0 : in_col_q;
    in_slot_b = restart ? '0 : in_slot_q;

    if (state_q == ST_IDLE && in_beat) begin
      in_row_d  = in_row_b;
      in_col_d  = in_col_b;
      in_slot_d = in_slot_b;
      if (restart) begin
        out_row_d  = '0;
        out_col_d  = '0;
        out_slot_d = '0;
      end
      // store the pixel; null pixels count as zero
      if (!s_axis_tuser && (in_row_b < h)) begin
        mem_we  = 1'b1;
        wcol    = (in_col_b < w) ? in_col_b : w - 1'b1;
        wr_data = s_axis_tdata[DEPTH_BITS] ? s_axis_tdata[DEPTH_BITS-1:0] : '0;
        if (wcol + 1'b1 >= w) begin
          in_col_d  = '0;
          in_row_d  = in_row_b + 1'b1;
          in_slot_d = (in_slot_b == SW'(STORE_ROWS - 1)) ? '0 : in_slot_b + 1'b1;
        end else begin
          in_col_d = wcol + 1'b1;
        end
      end
    end

    if (sel_start) begin
      last_d = (out_row_q == h - 1'b1) && (out_col_q >= w - 1'b1);
    end

    // hand the median to the output register, advance the output position
    if (state_q == ST_OUT && out_free) begin
      m_valid_d = 1'b1;
      m_depth_d = sel_med;
      m_flag_d  = (sel_med != '0);
      m_last_d  = last_q;
      if (last_q) begin
        in_row_d   = '0;
        in_col_d   = '0;
        in_slot_d  = '0;
        out_row_d  = '0;
        out_col_d  = '0;
        out_slot_d = '0;
      end else if (out_col_q + 1'b1 >= w) begin
        out_col_d  = '0;
        out_row_d  = out_row_q + 1'b1;
        out_slot_d = (out_slot_q == SW'(STORE_ROWS - 1)) ? '0 : out_slot_q + 1'b1;
      end else begin
        out_col_d = out_col_q + 1'b1;
      end
    end

    // width, height and radius register writes restart the frame
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WIDTH:  width_d  = cfg_data_i;
        CFG_HEIGHT: height_d = cfg_data_i;
        CFG_RADIUS: radius_d = cfg_data_i[RADIUS_W-1:0];
        default:    ;
      endcase
      if (cfg_idx_i == CFG_WIDTH || cfg_idx_i == CFG_HEIGHT || cfg_idx_i == CFG_RADIUS) begin
        in_row_d   = '0;
        in_col_d   = '0;
        in_slot_d  = '0;
        out_row_d  = '0;
        out_col_d  = '0;
        out_slot_d = '0;
      end
    end
  end

  assign wr_addr = AW'(32'(in_slot_b) * MAX_WIDTH) + AW'(wcol);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      width_q    <= RST_WIDTH;
      height_q   <= RST_HEIGHT;
      radius_q   <= RST_RADIUS;
      in_row_q   <= '0;
      in_col_q   <= '0;
      in_slot_q  <= '0;
      out_row_q  <= '0;
      out_col_q  <= '0;
      out_slot_q <= '0;
      last_q     <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      width_q    <= width_d;
      height_q   <= height_d;
      radius_q   <= radius_d;
      in_row_q   <= in_row_d;
      in_col_q   <= in_col_d;
      in_slot_q  <= in_slot_d;
      out_row_q  <= out_row_d;
      out_col_q  <= out_col_d;
      out_slot_q <= out_slot_d;
      last_q     <= last_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_depth_q <= m_depth_d;
    m_flag_q  <= m_flag_d;
    m_last_q  <= m_last_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = TDW'({m_flag_q, m_depth_q});
  assign m_axis_tlast  = m_last_q;

endmodule

[sv/dmmf_checker.sv]
// Port-level checker for the depth map median filter, bound to the top level.
`include "depth_map_median_filter_top_defines.svh"

module dmmf_checker #(
  parameter int DEPTH_BITS = 16,
  localparam int TDW       = ((DEPTH_BITS + 1 + 7) / 8) * 8
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           s_axis_tvalid,
  input logic           s_axis_tready,
  input logic           m_axis_tvalid,
  input logic           m_axis_tready,
  input logic [TDW-1:0] m_axis_tdata,
  input logic           m_axis_tlast
);

  `DMMF_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output beat dropped while stalled")
  `DMMF_ASSERT_NXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled output beat changed")
  `DMMF_ASSERT_IMP(a_null_flag, m_axis_tvalid, m_axis_tdata[DEPTH_BITS] == (m_axis_tdata[DEPTH_BITS-1:0] != '0), "valid mark disagrees with median depth")
  `DMMF_ASSERT_NXT(a_one_beat, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second input beat taken while one is in work")

endmodule

bind depth_map_median_filter_top dmmf_checker #(.DEPTH_BITS(DEPTH_BITS)) u_dmmf_checker (.*);
